// ===== hdl/lirs_pkg.sv =====
// ----------------------------------------------------------------------------
// lirs_pkg
// Shared types, sizes and codes for the LIRS replacement block.
// ----------------------------------------------------------------------------
package lirs_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int FIFO_DEPTH  = 32;
    localparam int KEY_WIDTH   = 32;

    localparam int SAW  = $clog2(STACK_DEPTH);
    localparam int SCW  = $clog2(STACK_DEPTH + 1);
    localparam int FAW  = $clog2(FIFO_DEPTH);
    localparam int FCW  = $clog2(FIFO_DEPTH + 1);
    localparam int CAPW = 6;
    localparam int CIW  = 2;

    localparam logic [CIW-1:0]  CFG_LIR_CAP = CIW'(0);
    localparam logic [CIW-1:0]  CFG_HIR_CAP = CIW'(1);
    localparam logic [CAPW-1:0] LIR_CAP_RST = CAPW'(16);
    localparam logic [CAPW-1:0] HIR_CAP_RST = CAPW'(4);

    // entry status in the recency stack
    typedef enum logic [1:0] {
        ST_LIR        = 2'd1,
        ST_HIR_RES    = 2'd2,
        ST_HIR_NONRES = 2'd3
    } t_st;

    typedef enum logic [2:0] {
        CLS_LIR_HIT     = 3'd0,
        CLS_RES_HIT     = 3'd1,
        CLS_NONRES_MISS = 3'd2,
        CLS_COLD_MISS   = 3'd3,
        CLS_FILL        = 3'd4
    } t_cls;

    typedef enum logic [1:0] {
        SM_KEY,
        SM_EVKEY,
        SM_STAT
    } t_smode;

    typedef struct packed {
        logic [KEY_WIDTH-1:0] key;
        t_st                  st;
    } t_sent;

    // datapath operations, one per cycle
    typedef enum logic [5:0] {
        D_NOP, D_START, D_SF_KEY, D_SF_EV, D_SF_NR, D_SF_RS, D_SF_LIR, D_SCHK,
        D_SREM_S, D_SREM_X, D_SREM_0, D_SREM_PR, D_SREM_WR, D_SREM_END,
        D_FF_INIT, D_FCHK, D_FREM_F, D_FREM_0, D_FREM_WR, D_FREM_END,
        D_PUSH_LIR, D_PUSH_RES, D_SPUSH_WR, D_FPK_KEY, D_FPK_TMP, D_FPUSH_WR,
        D_FI0, D_EV_LATCH, D_SET_NR, D_I0, D_TMP_LATCH, D_FINISH
    } t_dop;

    typedef enum logic [5:0] {
        S_IDLE, S_FIND, S_FFIND, S_DECIDE, S_A_PRUNE, S_A_PUSH, S_B_SEL,
        S_LIR_DEM, S_FPUSH_KEY, S_C_PUSH, S_D_PUSH,
        S_EV_0, S_EV_RD, S_EV_LAT, S_EV_SF, S_EV_SET, S_EV_DONE,
        S_DM_0, S_DM_1, S_DM_RD, S_DM_LAT, S_DM_2, S_DM_3,
        S_PU_CHK, S_PU_NR, S_PU_RS, S_PU_WR, S_PR_GO, S_PR_REM,
        S_FP_CHK, S_FP_WR,
        S_SF_RD, S_SF_CHK, S_SR_RD, S_SR_WR, S_SR_END,
        S_FF_RD, S_FF_CHK, S_FR_RD, S_FR_WR, S_FR_END, S_FIN
    } t_state;

    typedef struct packed {
        t_dop op;
        t_cls cls;
        logic lir_dec;
        logic hir_dec;
        logic cfg_ok;
    } t_cmd;

    typedef struct packed {
        logic i_lt_cnt;
        logic scan_hit;
        logic fi_lt_fcnt;
        logic fmatch;
        logic x_ok;
        logic s_ok;
        logic s_lir;
        logic f_ok;
        logic stack_full;
        logic stack_empty;
        logic fifo_empty;
        logic fifo_full;
        logic lir_nz;
        logic hir_nz;
        logic prune_zero;
        logic out_free;
    } t_stat;

    function automatic logic [CAPW-1:0] lir_load(input logic [CAPW-1:0] cap);
        return (int'(cap) < STACK_DEPTH - 1) ? cap : CAPW'(STACK_DEPTH - 1);
    endfunction

    function automatic logic [CAPW-1:0] hir_load(input logic [CAPW-1:0] cap);
        return (int'(cap) < FIFO_DEPTH) ? cap : CAPW'(FIFO_DEPTH);
    endfunction

endpackage

// ===== hdl/lirs_ram.sv =====
// ----------------------------------------------------------------------------
// lirs_ram
// Generic simple dual port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lirs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/lirs_ctrl.sv =====
// ----------------------------------------------------------------------------
// lirs_ctrl
// Sequencer for one access: search, classify, then run the stack and fifo
// routines (push, prune, fifo push, evict, demote) through return registers.
// ----------------------------------------------------------------------------
module lirs_ctrl import lirs_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  logic   i_cfg_valid,
    input  t_stat  i_stat,
    output logic   o_in_ready,
    output logic   o_cfg_ready,
    output t_cmd   o_cmd
);

    t_state r_state, n_state;
    t_state r_ret0, n_ret0;
    t_state r_ret1, n_ret1;
    t_cls   r_cls, n_cls;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret0  <= S_IDLE;
            r_ret1  <= S_IDLE;
            r_cls   <= CLS_FILL;
        end else begin
            r_state <= n_state;
            r_ret0  <= n_ret0;
            r_ret1  <= n_ret1;
            r_cls   <= n_cls;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_ret0  = r_ret0;
        n_ret1  = r_ret1;
        n_cls   = r_cls;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && !i_cfg_valid) begin
                    n_state = S_FIND;
                end
            end
            S_FIND: begin
                n_state = S_SF_RD;
                n_ret1  = S_FFIND;
            end
            S_FFIND: begin
                n_state = S_FF_RD;
                n_ret1  = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_stat.s_ok && i_stat.s_lir) begin
                    n_cls   = CLS_LIR_HIT;
                    n_state = S_SR_RD;
                    n_ret1  = S_A_PRUNE;
                end else if (i_stat.f_ok) begin
                    n_cls   = CLS_RES_HIT;
                    n_state = S_FR_RD;
                    n_ret1  = S_B_SEL;
                end else if (i_stat.lir_nz) begin
                    n_cls = CLS_FILL;
                    if (i_stat.s_ok) begin
                        n_state = S_SR_RD;
                        n_ret1  = S_C_PUSH;
                    end else begin
                        n_state = S_C_PUSH;
                    end
                end else if (i_stat.hir_nz) begin
                    n_cls = CLS_FILL;
                    if (i_stat.s_ok) begin
                        n_state = S_SR_RD;
                        n_ret1  = S_D_PUSH;
                    end else begin
                        n_state = S_D_PUSH;
                    end
                end else if (i_stat.s_ok) begin
                    n_cls   = CLS_NONRES_MISS;
                    n_state = S_EV_0;
                end else begin
                    n_cls   = CLS_COLD_MISS;
                    n_state = S_EV_0;
                end
            end
            S_A_PRUNE: begin
                n_state = S_PR_GO;
                n_ret0  = S_A_PUSH;
            end
            S_A_PUSH: begin
                n_state = S_PU_CHK;
                n_ret0  = S_FIN;
            end
            S_B_SEL: begin
                if (i_stat.s_ok) begin
                    n_state = S_SR_RD;
                    n_ret1  = S_LIR_DEM;
                end else begin
                    n_state = S_PU_CHK;
                    n_ret0  = S_FPUSH_KEY;
                end
            end
            S_LIR_DEM: begin
                n_state = S_PU_CHK;
                n_ret0  = S_DM_0;
            end
            S_FPUSH_KEY: begin
                n_state = S_FP_CHK;
                n_ret0  = S_FIN;
            end
            S_C_PUSH: begin
                n_state = S_PU_CHK;
                n_ret0  = S_FIN;
            end
            S_D_PUSH: begin
                n_state = S_PU_CHK;
                n_ret0  = S_FPUSH_KEY;
            end
            S_EV_0: begin
                n_state = i_stat.fifo_empty ? S_EV_DONE : S_EV_RD;
            end
            S_EV_RD: begin
                n_state = S_EV_LAT;
            end
            S_EV_LAT: begin
                n_state = S_FR_RD;
                n_ret1  = S_EV_SF;
            end
            S_EV_SF: begin
                n_state = S_SF_RD;
                n_ret1  = S_EV_SET;
            end
            S_EV_SET: begin
                n_state = S_EV_DONE;
            end
            S_EV_DONE: begin
                if (r_cls == CLS_NONRES_MISS) begin
                    n_state = S_SR_RD;
                    n_ret1  = S_LIR_DEM;
                end else begin
                    n_state = S_PU_CHK;
                    n_ret0  = S_FPUSH_KEY;
                end
            end
            S_DM_0: begin
                n_state = S_PR_GO;
                n_ret0  = S_DM_1;
            end
            S_DM_1: begin
                n_state = i_stat.stack_empty ? S_FIN : S_DM_RD;
            end
            S_DM_RD: begin
                n_state = S_DM_LAT;
            end
            S_DM_LAT: begin
                n_state = S_SR_RD;
                n_ret1  = S_DM_2;
            end
            S_DM_2: begin
                n_state = S_PR_GO;
                n_ret0  = S_DM_3;
            end
            S_DM_3: begin
                n_state = S_FP_CHK;
                n_ret0  = S_FIN;
            end
            S_PU_CHK: begin
                if (i_stat.stack_full) begin
                    n_state = S_SF_RD;
                    n_ret1  = S_PU_NR;
                end else begin
                    n_state = S_PU_WR;
                end
            end
            S_PU_NR: begin
                if (i_stat.x_ok) begin
                    n_state = S_SR_RD;
                    n_ret1  = S_PU_WR;
                end else begin
                    n_state = S_SF_RD;
                    n_ret1  = S_PU_RS;
                end
            end
            S_PU_RS: begin
                n_state = S_SR_RD;
                n_ret1  = S_PU_WR;
            end
            S_PU_WR: begin
                n_state = r_ret0;
            end
            S_PR_GO: begin
                n_state = S_SF_RD;
                n_ret1  = S_PR_REM;
            end
            S_PR_REM: begin
                if (i_stat.prune_zero) begin
                    n_state = r_ret0;
                end else begin
                    n_state = S_SR_RD;
                    n_ret1  = r_ret0;
                end
            end
            S_FP_CHK: begin
                if (i_stat.fifo_full) begin
                    n_state = S_FR_RD;
                    n_ret1  = S_FP_WR;
                end else begin
                    n_state = S_FP_WR;
                end
            end
            S_FP_WR: begin
                n_state = r_ret0;
            end
            S_SF_RD: begin
                n_state = i_stat.i_lt_cnt ? S_SF_CHK : r_ret1;
            end
            S_SF_CHK: begin
                n_state = i_stat.scan_hit ? r_ret1 : S_SF_RD;
            end
            S_SR_RD: begin
                n_state = i_stat.i_lt_cnt ? S_SR_WR : S_SR_END;
            end
            S_SR_WR: begin
                n_state = S_SR_RD;
            end
            S_SR_END: begin
                n_state = r_ret1;
            end
            S_FF_RD: begin
                n_state = i_stat.fi_lt_fcnt ? S_FF_CHK : r_ret1;
            end
            S_FF_CHK: begin
                n_state = i_stat.fmatch ? r_ret1 : S_FF_RD;
            end
            S_FR_RD: begin
                n_state = i_stat.fi_lt_fcnt ? S_FR_WR : S_FR_END;
            end
            S_FR_WR: begin
                n_state = S_FR_RD;
            end
            S_FR_END: begin
                n_state = r_ret1;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd         = '0;
        o_cmd.op      = D_NOP;
        o_cmd.cls     = r_cls;
        o_in_ready    = 1'b0;
        o_cfg_ready   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_cfg_ready  = i_rst_n;
                o_cmd.cfg_ok = i_rst_n && i_cfg_valid;
                o_in_ready   = i_rst_n && !i_cfg_valid;
                if (i_in_valid && !i_cfg_valid) begin
                    o_cmd.op = D_START;
                end
            end
            S_FIND:      o_cmd.op = D_SF_KEY;
            S_FFIND:     o_cmd.op = D_FF_INIT;
            S_DECIDE: begin
                if (i_stat.s_ok && i_stat.s_lir) begin
                    o_cmd.op = D_SREM_S;
                end else if (i_stat.f_ok) begin
                    o_cmd.op = D_FREM_F;
                end else if ((i_stat.lir_nz || i_stat.hir_nz) && i_stat.s_ok) begin
                    o_cmd.op = D_SREM_S;
                end
            end
            S_A_PUSH:    o_cmd.op = D_PUSH_LIR;
            S_B_SEL:     o_cmd.op = i_stat.s_ok ? D_SREM_S : D_PUSH_RES;
            S_LIR_DEM:   o_cmd.op = D_PUSH_LIR;
            S_FPUSH_KEY: o_cmd.op = D_FPK_KEY;
            S_C_PUSH: begin
                o_cmd.op      = D_PUSH_LIR;
                o_cmd.lir_dec = 1'b1;
            end
            S_D_PUSH: begin
                o_cmd.op      = D_PUSH_RES;
                o_cmd.hir_dec = 1'b1;
            end
            S_EV_0:      o_cmd.op = i_stat.fifo_empty ? D_NOP : D_FI0;
            S_EV_LAT:    o_cmd.op = D_EV_LATCH;
            S_EV_SF:     o_cmd.op = D_SF_EV;
            S_EV_SET:    o_cmd.op = i_stat.x_ok ? D_SET_NR : D_NOP;
            S_EV_DONE: begin
                o_cmd.op = (r_cls == CLS_NONRES_MISS) ? D_SREM_S : D_PUSH_RES;
            end
            S_DM_1:      o_cmd.op = i_stat.stack_empty ? D_NOP : D_I0;
            S_DM_LAT:    o_cmd.op = D_TMP_LATCH;
            S_DM_3:      o_cmd.op = D_FPK_TMP;
            S_PU_CHK:    o_cmd.op = i_stat.stack_full ? D_SF_NR : D_NOP;
            S_PU_NR:     o_cmd.op = i_stat.x_ok ? D_SREM_X : D_SF_RS;
            S_PU_RS:     o_cmd.op = i_stat.x_ok ? D_SREM_X : D_SREM_0;
            S_PU_WR:     o_cmd.op = D_SPUSH_WR;
            S_PR_GO:     o_cmd.op = D_SF_LIR;
            S_PR_REM:    o_cmd.op = i_stat.prune_zero ? D_NOP : D_SREM_PR;
            S_FP_CHK:    o_cmd.op = i_stat.fifo_full ? D_FREM_0 : D_NOP;
            S_FP_WR:     o_cmd.op = D_FPUSH_WR;
            S_SF_CHK:    o_cmd.op = D_SCHK;
            S_SR_WR:     o_cmd.op = D_SREM_WR;
            S_SR_END:    o_cmd.op = D_SREM_END;
            S_FF_CHK:    o_cmd.op = D_FCHK;
            S_FR_WR:     o_cmd.op = D_FREM_WR;
            S_FR_END:    o_cmd.op = D_FREM_END;
            S_FIN:       o_cmd.op = i_stat.out_free ? D_FINISH : D_NOP;
            default:     o_cmd.op = D_NOP;
        endcase
    end

endmodule

// ===== hdl/lirs_dpath.sv =====
// ----------------------------------------------------------------------------
// lirs_dpath
// Stack and fifo memories, index and count registers, search compare,
// counters and the result register.
// ----------------------------------------------------------------------------
module lirs_dpath import lirs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  logic [31:0]          i_access_key,
    input  logic [CIW-1:0]       i_cfg_index,
    input  logic [CAPW-1:0]      i_cfg_data,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic                 o_hit,
    output logic [2:0]           o_access_class,
    output logic                 o_evicted_valid,
    output logic [31:0]          o_evicted_key,
    output logic [31:0]          o_hit_total,
    output logic [31:0]          o_miss_total,
    output logic                 o_stack_overflow
);

    logic [KEY_WIDTH-1:0] r_key, r_evkey, r_tmp, r_fpk;
    logic                 r_ev, r_ovf;
    logic [SCW-1:0]       r_cnt, r_i, r_k, r_x, r_s;
    logic                 r_x_ok, r_s_ok, r_f_ok;
    t_st                  r_xst, r_sst, r_tst, r_pst;
    t_smode               r_mode;
    logic [FCW-1:0]       r_fcnt, r_fi, r_f;
    logic [CAPW-1:0]      r_lir_cap, r_hir_cap, r_lir_free, r_hir_free;
    logic [31:0]          r_hits, r_misses;
    logic                 r_out_valid, r_o_hit, r_o_ev, r_o_ovf;
    t_cls                 r_o_cls;
    logic [KEY_WIDTH-1:0] r_o_evkey;

    t_sent                s_rdata, s_wdata;
    logic                 s_we;
    logic [SAW-1:0]       s_waddr;
    logic [SCW-1:0]       w_sub, w_prk;
    logic [KEY_WIDTH-1:0] f_rdata, f_wdata;
    logic                 f_we;
    logic [FAW-1:0]       f_waddr;
    logic [FCW-1:0]       w_fsub;
    logic                 w_scan_hit, w_fmatch, w_hit;
    logic [CAPW-1:0]      w_lir_cap, w_hir_cap;

    assign w_sub   = r_i - r_k;
    assign w_fsub  = r_fi - FCW'(1);
    assign w_prk   = r_x_ok ? r_x : r_cnt;
    assign w_fmatch = (f_rdata == r_key);

    // search compare per scan mode
    always_comb begin
        case (r_mode)
            SM_KEY:   w_scan_hit = (s_rdata.key == r_key);
            SM_EVKEY: w_scan_hit = (s_rdata.key == r_evkey);
            SM_STAT:  w_scan_hit = (s_rdata.st == r_tst);
            default:  w_scan_hit = 1'b0;
        endcase
    end

    // memory write selection
    always_comb begin
        s_we    = 1'b0;
        s_waddr = w_sub[SAW-1:0];
        s_wdata = s_rdata;
        f_we    = 1'b0;
        f_waddr = w_fsub[FAW-1:0];
        f_wdata = f_rdata;
        case (i_cmd.op)
            D_SREM_WR: s_we = 1'b1;
            D_SPUSH_WR: begin
                s_we    = 1'b1;
                s_waddr = r_cnt[SAW-1:0];
                s_wdata = '{key: r_key, st: r_pst};
            end
            D_SET_NR: begin
                s_we    = 1'b1;
                s_waddr = r_x[SAW-1:0];
                s_wdata = '{key: r_evkey, st: ST_HIR_NONRES};
            end
            D_FREM_WR: f_we = 1'b1;
            D_FPUSH_WR: begin
                f_we    = 1'b1;
                f_waddr = r_fcnt[FAW-1:0];
                f_wdata = r_fpk;
            end
            default: ;
        endcase
    end

    lirs_ram #(.WIDTH($bits(t_sent)), .DEPTH(STACK_DEPTH)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (r_i[SAW-1:0]),
        .o_rdata (s_rdata)
    );

    lirs_ram #(.WIDTH(KEY_WIDTH), .DEPTH(FIFO_DEPTH)) u_fifo_ram (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr),
        .i_wdata (f_wdata),
        .i_raddr (r_fi[FAW-1:0]),
        .o_rdata (f_rdata)
    );

    // new capacities on a configuration transaction
    assign w_lir_cap = (i_cmd.cfg_ok && i_cfg_index == CFG_LIR_CAP) ? i_cfg_data : r_lir_cap;
    assign w_hir_cap = (i_cmd.cfg_ok && i_cfg_index == CFG_HIR_CAP) ? i_cfg_data : r_hir_cap;
    assign w_hit     = (i_cmd.cls == CLS_LIR_HIT) || (i_cmd.cls == CLS_RES_HIT);

    // register transfers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lir_cap   <= LIR_CAP_RST;
            r_hir_cap   <= HIR_CAP_RST;
            r_lir_free  <= lir_load(LIR_CAP_RST);
            r_hir_free  <= hir_load(HIR_CAP_RST);
            r_cnt       <= '0;
            r_fcnt      <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_out_valid <= 1'b0;
            r_x_ok      <= 1'b0;
            r_s_ok      <= 1'b0;
            r_f_ok      <= 1'b0;
            r_i         <= '0;
            r_fi        <= '0;
            r_mode      <= SM_KEY;
        end else begin
            // result valid: set on finish, cleared when taken
            if (i_cmd.op == D_FINISH) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.cfg_ok && (i_cfg_index == CFG_LIR_CAP || i_cfg_index == CFG_HIR_CAP)) begin
                r_lir_cap  <= w_lir_cap;
                r_hir_cap  <= w_hir_cap;
                r_lir_free <= lir_load(w_lir_cap);
                r_hir_free <= hir_load(w_hir_cap);
                r_cnt      <= '0;
                r_fcnt     <= '0;
            end
            if (i_cmd.lir_dec) begin
                r_lir_free <= r_lir_free - CAPW'(1);
            end
            if (i_cmd.hir_dec) begin
                r_hir_free <= r_hir_free - CAPW'(1);
            end
            case (i_cmd.op)
                D_START: begin
                    r_key   <= KEY_WIDTH'(i_access_key);
                    r_ev    <= 1'b0;
                    r_evkey <= '0;
                    r_ovf   <= 1'b0;
                end
                D_SF_KEY: begin
                    r_i <= '0; r_x_ok <= 1'b0; r_mode <= SM_KEY;
                end
                D_SF_EV: begin
                    r_i <= '0; r_x_ok <= 1'b0; r_mode <= SM_EVKEY;
                end
                D_SF_NR: begin
                    r_i <= '0; r_x_ok <= 1'b0; r_mode <= SM_STAT;
                    r_tst <= ST_HIR_NONRES;
                    r_ovf <= 1'b1;
                end
                D_SF_RS: begin
                    r_i <= '0; r_x_ok <= 1'b0; r_mode <= SM_STAT;
                    r_tst <= ST_HIR_RES;
                end
                D_SF_LIR: begin
                    r_i <= '0; r_x_ok <= 1'b0; r_mode <= SM_STAT;
                    r_tst <= ST_LIR;
                end
                D_SCHK: begin
                    if (w_scan_hit) begin
                        r_x    <= r_i;
                        r_x_ok <= 1'b1;
                        r_xst  <= s_rdata.st;
                    end else begin
                        r_i <= r_i + SCW'(1);
                    end
                end
                D_SREM_S: begin
                    r_i <= r_s + SCW'(1); r_k <= SCW'(1);
                end
                D_SREM_X: begin
                    r_i <= r_x + SCW'(1); r_k <= SCW'(1);
                end
                D_SREM_0: begin
                    r_i <= SCW'(1); r_k <= SCW'(1);
                end
                D_SREM_PR: begin
                    r_i <= w_prk; r_k <= w_prk;
                end
                D_SREM_WR:  r_i <= r_i + SCW'(1);
                D_SREM_END: r_cnt <= r_cnt - r_k;
                D_FF_INIT: begin
                    r_s    <= r_x;
                    r_s_ok <= r_x_ok;
                    r_sst  <= r_xst;
                    r_fi   <= '0;
                    r_f_ok <= 1'b0;
                end
                D_FCHK: begin
                    if (w_fmatch) begin
                        r_f    <= r_fi;
                        r_f_ok <= 1'b1;
                    end else begin
                        r_fi <= r_fi + FCW'(1);
                    end
                end
                D_FREM_F:   r_fi <= r_f + FCW'(1);
                D_FREM_0:   r_fi <= FCW'(1);
                D_FREM_WR:  r_fi <= r_fi + FCW'(1);
                D_FREM_END: r_fcnt <= r_fcnt - FCW'(1);
                D_PUSH_LIR: r_pst <= ST_LIR;
                D_PUSH_RES: r_pst <= ST_HIR_RES;
                D_SPUSH_WR: r_cnt <= r_cnt + SCW'(1);
                D_FPK_KEY:  r_fpk <= r_key;
                D_FPK_TMP:  r_fpk <= r_tmp;
                D_FPUSH_WR: r_fcnt <= r_fcnt + FCW'(1);
                D_FI0:      r_fi <= '0;
                D_EV_LATCH: begin
                    r_evkey <= f_rdata;
                    r_ev    <= 1'b1;
                    r_fi    <= FCW'(1);
                end
                D_I0: r_i <= '0;
                D_TMP_LATCH: begin
                    r_tmp <= s_rdata.key;
                    r_i   <= SCW'(1);
                    r_k   <= SCW'(1);
                end
                D_FINISH: begin
                    r_o_hit     <= w_hit;
                    r_o_cls     <= i_cmd.cls;
                    r_o_ev      <= r_ev;
                    r_o_evkey   <= r_evkey;
                    r_o_ovf     <= r_ovf;
                    if (w_hit) begin
                        r_hits <= r_hits + 32'd1;
                    end else begin
                        r_misses <= r_misses + 32'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // status to the sequencer
    always_comb begin
        o_stat.i_lt_cnt    = (r_i < r_cnt);
        o_stat.scan_hit    = w_scan_hit;
        o_stat.fi_lt_fcnt  = (r_fi < r_fcnt);
        o_stat.fmatch      = w_fmatch;
        o_stat.x_ok        = r_x_ok;
        o_stat.s_ok        = r_s_ok;
        o_stat.s_lir       = (r_sst == ST_LIR);
        o_stat.f_ok        = r_f_ok;
        o_stat.stack_full  = (r_cnt == SCW'(STACK_DEPTH));
        o_stat.stack_empty = (r_cnt == '0);
        o_stat.fifo_empty  = (r_fcnt == '0);
        o_stat.fifo_full   = (r_fcnt == FCW'(FIFO_DEPTH));
        o_stat.lir_nz      = (r_lir_free != '0);
        o_stat.hir_nz      = (r_hir_free != '0);
        o_stat.prune_zero  = (w_prk == '0);
        o_stat.out_free    = !r_out_valid || i_out_ready;
    end

    assign o_out_valid      = r_out_valid;
    assign o_hit            = r_o_hit;
    assign o_access_class   = r_o_cls;
    assign o_evicted_valid  = r_o_ev;
    assign o_evicted_key    = 32'(r_o_evkey);
    assign o_hit_total      = r_hits;
    assign o_miss_total     = r_misses;
    assign o_stack_overflow = r_o_ovf;

endmodule

// ===== hdl/lirs_cache_replacement.sv =====
// Access time grows with the N stack and M fifo entries searched for a plain fill; hits,
// evictions, demotion and overflow add stack scans and shifts.
// Throughput: one access at a time; the next can be taken the cycle after the result is
// loaded, and a result not yet taken holds the following access in its last step.
// Reset: synchronous, active low; counters clear, stack and fifo empty, capacities reload.
// ----------------------------------------------------------------------------
// lirs_cache_replacement
// LIRS replacement top level: sequencer plus stack/fifo datapath.
// ----------------------------------------------------------------------------
module lirs_cache_replacement import lirs_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [31:0]     i_access_key,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic            o_hit,
    output logic [2:0]      o_access_class,
    output logic            o_evicted_valid,
    output logic [31:0]     o_evicted_key,
    output logic [31:0]     o_hit_total,
    output logic [31:0]     o_miss_total,
    output logic            o_stack_overflow,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [CIW-1:0]  i_cfg_index,
    input  logic [CAPW-1:0] i_cfg_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    lirs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cfg_valid (i_cfg_valid),
        .i_stat      (w_stat),
        .o_in_ready  (o_in_ready),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (w_cmd)
    );

    lirs_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_access_key     (i_access_key),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_hit            (o_hit),
        .o_access_class   (o_access_class),
        .o_evicted_valid  (o_evicted_valid),
        .o_evicted_key    (o_evicted_key),
        .o_hit_total      (o_hit_total),
        .o_miss_total     (o_miss_total),
        .o_stack_overflow (o_stack_overflow)
    );

endmodule

// ===== bench/lirs_cache_checker.sv =====
// ----------------------------------------------------------------------------
// lirs_cache_checker
// Watches the access, result and register channels of the LIRS replacement
// block, keeps its own LIRS stack and cold-block queue, and compares every
// result transaction field by field with the predicted one.
// ----------------------------------------------------------------------------
module lirs_cache_checker import lirs_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_ready,
    input  logic [31:0]     i_access_key,
    input  logic            i_out_valid,
    input  logic            i_out_ready,
    input  logic            i_hit,
    input  logic [2:0]      i_access_class,
    input  logic            i_evicted_valid,
    input  logic [31:0]     i_evicted_key,
    input  logic [31:0]     i_hit_total,
    input  logic [31:0]     i_miss_total,
    input  logic            i_stack_overflow,
    input  logic            i_cfg_valid,
    input  logic            i_cfg_ready,
    input  logic [CIW-1:0]  i_cfg_index,
    input  logic [CAPW-1:0] i_cfg_data,
    output int              o_fail_count,
    output int              o_pending,
    output int              o_class_seen [5],
    output int              o_overflow_seen
);

    typedef struct packed {
        logic        hit;
        t_cls        cls;
        logic        ev_valid;
        logic [31:0] ev_key;
        logic [31:0] hits;
        logic [31:0] misses;
        logic        ovf;
    } t_access_result;

    typedef struct {
        logic [31:0] key;
        t_st         st;
    } t_entry;

    t_access_result result_q[$];
    t_entry         recency[$];
    logic [31:0]    cold_q[$];
    logic [CAPW-1:0] lir_cap, hir_cap;
    int unsigned    lir_left, hir_left;
    logic [31:0]    hit_cnt, miss_cnt;

    // clear stack and queue, reload free slots with clamping
    function automatic void reload_slots();
        recency.delete();
        cold_q.delete();
        lir_left = (lir_cap < STACK_DEPTH - 1) ? lir_cap : STACK_DEPTH - 1;
        hir_left = (hir_cap < FIFO_DEPTH) ? hir_cap : FIFO_DEPTH;
    endfunction

    function automatic int find_recency(logic [31:0] key);
        foreach (recency[i]) if (recency[i].key == key) return i;
        return -1;
    endfunction

    function automatic int find_cold(logic [31:0] key);
        foreach (cold_q[i]) if (cold_q[i] == key) return i;
        return -1;
    endfunction

    function automatic int oldest_with(t_st st);
        foreach (recency[i]) if (recency[i].st == st) return i;
        return -1;
    endfunction

    // push on top, dropping an old entry when the stack is full
    function automatic logic push_recency(logic [31:0] key, t_st st);
        int v;
        logic dropped;
        t_entry e;
        dropped = 1'b0;
        if (recency.size() >= STACK_DEPTH) begin
            v = oldest_with(ST_HIR_NONRES);
            if (v < 0) v = oldest_with(ST_HIR_RES);
            if (v < 0) v = 0;
            recency.delete(v);
            dropped = 1'b1;
        end
        e.key = key;
        e.st  = st;
        recency.insert(recency.size(), e);
        return dropped;
    endfunction

    function automatic void prune_bottom();
        while (recency.size() > 0 && recency[0].st != ST_LIR) recency.delete(0);
    endfunction

    function automatic void push_cold(logic [31:0] key);
        if (cold_q.size() >= FIFO_DEPTH) cold_q.delete(0);
        cold_q.insert(cold_q.size(), key);
    endfunction

    // move the bottom hot block to the cold queue tail
    function automatic void demote_hot_bottom();
        logic [31:0] k;
        prune_bottom();
        if (recency.size() == 0) return;
        k = recency[0].key;
        recency.delete(0);
        prune_bottom();
        push_cold(k);
    endfunction

    function automatic t_access_result predict_access(logic [31:0] key);
        t_access_result r;
        int s, f;
        r = '0;
        s = find_recency(key);
        f = find_cold(key);
        if (s >= 0 && recency[s].st == ST_LIR) begin
            r.cls = CLS_LIR_HIT;
            r.hit = 1'b1;
            recency.delete(s);
            prune_bottom();
            r.ovf = push_recency(key, ST_LIR);
        end else if (f >= 0) begin
            r.cls = CLS_RES_HIT;
            r.hit = 1'b1;
            cold_q.delete(f);
            if (s >= 0) begin
                recency.delete(s);
                r.ovf = push_recency(key, ST_LIR);
                demote_hot_bottom();
            end else begin
                r.ovf = push_recency(key, ST_HIR_RES);
                push_cold(key);
            end
        end else if (lir_left > 0) begin
            r.cls = CLS_FILL;
            if (s >= 0) recency.delete(s);
            r.ovf = push_recency(key, ST_LIR);
            lir_left--;
        end else if (hir_left > 0) begin
            r.cls = CLS_FILL;
            if (s >= 0) recency.delete(s);
            r.ovf = push_recency(key, ST_HIR_RES);
            push_cold(key);
            hir_left--;
        end else begin
            // miss with no free slot: evict the cold queue head first
            r.cls = (s >= 0) ? CLS_NONRES_MISS : CLS_COLD_MISS;
            if (cold_q.size() > 0) begin
                r.ev_valid = 1'b1;
                r.ev_key   = cold_q[0];
                cold_q.delete(0);
                s = find_recency(r.ev_key);
                if (s >= 0) recency[s].st = ST_HIR_NONRES;
            end
            if (r.cls == CLS_NONRES_MISS) begin
                s = find_recency(key);
                if (s >= 0) recency.delete(s);
                r.ovf = push_recency(key, ST_LIR);
                demote_hot_bottom();
            end else begin
                r.ovf = push_recency(key, ST_HIR_RES);
                push_cold(key);
            end
        end
        if (r.hit) hit_cnt++;
        else miss_cnt++;
        r.hits   = hit_cnt;
        r.misses = miss_cnt;
        return r;
    endfunction

    t_access_result got, want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lir_cap  = LIR_CAP_RST;
            hir_cap  = HIR_CAP_RST;
            hit_cnt  = '0;
            miss_cnt = '0;
            recency.delete();
            cold_q.delete();
            lir_left = LIR_CAP_RST;
            hir_left = HIR_CAP_RST;
            result_q.delete();
            o_fail_count    <= 0;
            o_overflow_seen <= 0;
            foreach (o_class_seen[i]) o_class_seen[i] <= 0;
        end else begin
            // register write flushes the cache state
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_LIR_CAP) lir_cap = i_cfg_data;
                else if (i_cfg_index == CFG_HIR_CAP) hir_cap = i_cfg_data;
                reload_slots();
            end
            if (i_in_valid && i_in_ready) begin
                result_q.insert(result_q.size(), predict_access(i_access_key));
            end
            // result transaction compare
            if (i_out_valid && i_out_ready) begin
                got = '{i_hit, t_cls'(i_access_class), i_evicted_valid, i_evicted_key,
                        i_hit_total, i_miss_total, i_stack_overflow};
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result transaction %p", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = result_q[0];
                    result_q.delete(0);
                    if (got !== want) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, got);
                        o_fail_count <= o_fail_count + 1;
                    end
                    if (want.cls <= CLS_FILL) o_class_seen[want.cls] <= o_class_seen[want.cls] + 1;
                    if (want.ovf) o_overflow_seen <= o_overflow_seen + 1;
                end
            end
        end
        o_pending = result_q.size();
    end

endmodule

// ===== bench/tb_lirs_cache_replacement.sv =====
// ----------------------------------------------------------------------------
// tb_lirs_cache_replacement
// Drives access keys from small and large key pools through several capacity
// settings with random idling on both sides and a long result back-pressure
// stretch; the checker predicts and compares each result.
// ----------------------------------------------------------------------------
module tb_lirs_cache_replacement;
    import lirs_pkg::*;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_in_valid;
    logic            o_in_ready;
    logic [31:0]     i_access_key;
    logic            o_out_valid;
    logic            i_out_ready;
    logic            o_hit;
    logic [2:0]      o_access_class;
    logic            o_evicted_valid;
    logic [31:0]     o_evicted_key;
    logic [31:0]     o_hit_total;
    logic [31:0]     o_miss_total;
    logic            o_stack_overflow;
    logic            i_cfg_valid;
    logic            o_cfg_ready;
    logic [CIW-1:0]  i_cfg_index;
    logic [CAPW-1:0] i_cfg_data;

    int fail_count, pending, overflow_seen;
    int class_seen [5];
    int send_idle_pct, recv_idle_pct;
    logic hold_request;
    int hold_count = 0;
    logic [31:0] key_pool [64];

    lirs_cache_replacement dut (.*);

    lirs_cache_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready), .i_access_key(i_access_key),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready), .i_hit(o_hit),
        .i_access_class(o_access_class), .i_evicted_valid(o_evicted_valid),
        .i_evicted_key(o_evicted_key), .i_hit_total(o_hit_total),
        .i_miss_total(o_miss_total), .i_stack_overflow(o_stack_overflow),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_class_seen(class_seen), .o_overflow_seen(overflow_seen)
    );

    always begin
        i_clk = 1'b0; #2;
        i_clk = 1'b1; #2;
    end

    // receiver: random idling, plus one long hold-off when asked
    always @(posedge i_clk) begin
        if (hold_request && hold_count < 400) begin
            hold_count  <= hold_count + 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // one access transaction, with random gaps before it
    task automatic send_access(input logic [31:0] key);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_access_key <= key;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // register write once every result has been taken
    task automatic write_capacity(input logic [CIW-1:0] idx, input logic [CAPW-1:0] val);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // random phase: mostly reuse from a pool sized around the cache, some fresh keys
    task automatic random_phase(input int count, input int pool_size);
        logic [31:0] key;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(9) < 8) key = key_pool[$urandom_range(pool_size - 1)];
            else key = $urandom();
            send_access(key);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_access_key = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_LIR_CAP;
        i_cfg_data = '0;
        send_idle_pct = 36;
        recv_idle_pct = 69;
        hold_request = 1'b0;
        foreach (key_pool[i]) key_pool[i] = $urandom();
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset capacities, warm-up fills, hits of each kind
        for (int i = 0; i < 20; i++) send_access(key_pool[i]);
        send_access(key_pool[0]);
        send_access(key_pool[18]);
        send_access(key_pool[1]);
        send_access(key_pool[19]);
        send_access(key_pool[2]);

        // small capacities drive promotion and demotion hard
        write_capacity(CFG_LIR_CAP, CAPW'(2));
        write_capacity(CFG_HIR_CAP, CAPW'(2));
        random_phase(200, 6);

        // long result hold-off while accesses keep coming
        hold_request = 1'b1;
        random_phase(30, 6);

        // largest register values, hir clamped to the fifo depth; pool large enough to fill the stack
        write_capacity(CFG_LIR_CAP, CAPW'(63));
        write_capacity(CFG_HIR_CAP, CAPW'(63));
        send_idle_pct = 69;
        recv_idle_pct = 36;
        for (int i = 0; i < 160; i++) send_access(32'h1000_0000 + i);
        random_phase(100, 64);

        write_capacity(CFG_LIR_CAP, CAPW'(5));
        write_capacity(CFG_HIR_CAP, CAPW'(3));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(325, 16);

        // zero lir capacity with roomy hir, then small lir and hir
        write_capacity(CFG_LIR_CAP, CAPW'(0));
        write_capacity(CFG_HIR_CAP, CAPW'(32));
        random_phase(80, 40);
        write_capacity(CFG_LIR_CAP, CAPW'(1));
        write_capacity(CFG_HIR_CAP, CAPW'(1));
        random_phase(80, 5);

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (800) @(posedge i_clk);
        $display("coverage: lir hits %0d, resident hits %0d, nonresident misses %0d",
                 class_seen[0], class_seen[1], class_seen[2]);
        $display("coverage: cold misses %0d, fills %0d, stack overflows %0d",
                 class_seen[3], class_seen[4], overflow_seen);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // watchdog
    initial begin
        #40000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/lirs_pkg.sv
hdl/lirs_ram.sv
hdl/lirs_ctrl.sv
hdl/lirs_dpath.sv
hdl/lirs_cache_replacement.sv
bench/lirs_cache_checker.sv
bench/tb_lirs_cache_replacement.sv
